>>> sv/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/rlp_pkg.sv
`default_nettype none
package rlp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_only;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ok;
    } t_out_item;

    localparam logic [2:0] CLS_DEC     = 3'd0;
    localparam logic [2:0] CLS_LOWER   = 3'd1;
    localparam logic [2:0] CLS_UPPER   = 3'd2;
    localparam logic [2:0] CLS_SPECIAL = 3'd3;
    localparam logic [2:0] CLS_HASH    = 3'd4;
    localparam logic [2:0] CLS_OTHER   = 3'd5;

    typedef struct packed {
        logic [2:0] cls;
        logic       is_x;
        logic [5:0] dv;
        logic       end_only;
        logic       last;
    } t_cls_item;

    localparam logic [6:0] BASE_MIN    = 7'd2;
    localparam logic [6:0] BASE_MAX    = 7'd64;
    localparam logic [6:0] BASE_HEX    = 7'd16;
    localparam logic [6:0] BASE_OCT    = 7'd8;
    localparam logic [6:0] BASE_DEC    = 7'd10;
    localparam logic [6:0] CASE_SPLIT  = 7'd36;
    localparam logic [6:0] PREFIX_SAT  = 7'd65;
    localparam logic [5:0] DIGIT_AT    = 6'd62;
    localparam logic [5:0] DIGIT_UNDER = 6'd63;

    localparam logic       MODE_PREFIX = 1'b0;
    localparam logic       MODE_DIGITS = 1'b1;
    localparam logic [1:0] POS_MAX     = 2'd2;

endpackage
`default_nettype wire

>>> sv/rlp_front.sv
`default_nettype none
module rlp_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rlp_pkg::t_in_item  i_in_data,
    input  wire logic               i_full,
    output logic                    o_item_valid,
    output rlp_pkg::t_cls_item      o_item
);
    import rlp_pkg::*;

    logic      r_valid;
    t_cls_item r_item;
    t_cls_item n_item;
    logic      accept;

    assign o_in_stall   = r_valid && i_full;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_item.end_only = i_in_data.end_only;
        n_item.last     = i_in_data.last;
        n_item.is_x     = (i_in_data.ch == "x") || (i_in_data.ch == "X");
        n_item.cls      = CLS_OTHER;
        n_item.dv       = '0;
        if (i_in_data.ch inside {["0":"9"]}) begin
            n_item.cls = CLS_DEC;
            n_item.dv  = 6'(i_in_data.ch - 8'h30);
        end else if (i_in_data.ch inside {["a":"z"]}) begin
            n_item.cls = CLS_LOWER;
            n_item.dv  = 6'(i_in_data.ch - 8'h61 + 8'd10);
        end else if (i_in_data.ch inside {["A":"Z"]}) begin
            n_item.cls = CLS_UPPER;
            n_item.dv  = 6'(i_in_data.ch - 8'h41);
        end else if (i_in_data.ch == "@") begin
            n_item.cls = CLS_SPECIAL;
            n_item.dv  = DIGIT_AT;
        end else if (i_in_data.ch == "_") begin
            n_item.cls = CLS_SPECIAL;
            n_item.dv  = DIGIT_UNDER;
        end else if (i_in_data.ch == "#") begin
            n_item.cls = CLS_HASH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

>>> sv/rlp_queue.sv
`default_nettype none
`include "assert_macros.svh"
module rlp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire rlp_pkg::t_cls_item i_push_item,
    output logic                    o_full,
    output logic                    o_pop_valid,
    output rlp_pkg::t_cls_item      o_pop_item,
    input  wire logic               i_pop
);
    import rlp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_item  = r_mem[r_rd_ptr];
    assign push        = i_push && !o_full;
    assign pop         = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

>>> sv/rlp_back.sv
`default_nettype none
`include "assert_macros.svh"
module rlp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire rlp_pkg::t_cls_item i_q_item,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rlp_pkg::t_out_item      o_out_data
);
    import rlp_pkg::*;

    logic [1:0]  r_pos,   n_pos;
    logic        r_fz,    n_fz;
    logic        r_mode,  n_mode;
    logic [6:0]  r_pv,    n_pv;
    logic [6:0]  r_radix, n_radix;
    logic [63:0] r_acc,   n_acc;
    logic        r_obd,   n_obd;
    logic        r_rej,   n_rej;

    logic        r_out_valid;
    t_out_item   r_out_data;
    t_out_item   result;

    logic        out_free;
    logic [6:0]  dig;
    logic        dig_ok;
    logic [5:0]  mac_add;
    logic [63:0] mac;
    logic [9:0]  pv_next;
    logic        good;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = i_q_valid && (!i_q_item.last || out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        dig    = {1'b0, i_q_item.dv};
        dig_ok = 1'b1;
        case (i_q_item.cls)
            CLS_DEC, CLS_LOWER, CLS_SPECIAL: begin
                dig = {1'b0, i_q_item.dv};
            end
            CLS_UPPER: begin
                dig = {1'b0, i_q_item.dv} + ((r_radix <= CASE_SPLIT) ? BASE_DEC : CASE_SPLIT);
            end
            default: begin
                dig    = '0;
                dig_ok = 1'b0;
            end
        endcase
    end

    assign mac_add = (r_mode == MODE_DIGITS) ? dig[5:0] : i_q_item.dv;
    assign mac     = r_acc * {57'd0, r_radix} + {58'd0, mac_add};
    assign pv_next = {3'd0, r_pv} * 10'd10 + {4'd0, i_q_item.dv};

    always_comb begin
        n_pos   = r_pos;
        n_fz    = r_fz;
        n_mode  = r_mode;
        n_pv    = r_pv;
        n_radix = r_radix;
        n_acc   = r_acc;
        n_obd   = r_obd;
        n_rej   = r_rej;
        if (o_pop && !i_q_item.end_only && !r_rej) begin
            if (r_mode == MODE_DIGITS) begin
                if (!dig_ok || dig >= r_radix) begin
                    n_rej = 1'b1;
                end else begin
                    n_acc = mac;
                end
            end else if (r_pos == 2'd1 && r_fz && i_q_item.is_x) begin
                n_mode  = MODE_DIGITS;
                n_radix = BASE_HEX;
                n_acc   = '0;
                n_pos   = POS_MAX;
            end else if (i_q_item.cls == CLS_DEC) begin
                n_pv = (pv_next > {3'd0, PREFIX_SAT}) ? PREFIX_SAT : pv_next[6:0];
                if (r_pos == 2'd0) begin
                    n_fz    = (i_q_item.dv == '0);
                    n_radix = (i_q_item.dv == '0) ? BASE_OCT : BASE_DEC;
                    n_acc   = {58'd0, i_q_item.dv};
                end else begin
                    if (r_radix == BASE_OCT && i_q_item.dv >= 6'(BASE_OCT)) begin
                        n_obd = 1'b1;
                    end
                    n_acc = mac;
                end
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end else if (i_q_item.cls == CLS_HASH) begin
                if (r_pv < BASE_MIN || r_pv > BASE_MAX || (r_pv == BASE_DEC && r_fz)) begin
                    n_rej = 1'b1;
                end else begin
                    n_mode  = MODE_DIGITS;
                    n_radix = r_pv;
                    n_acc   = '0;
                    if (r_pos != POS_MAX) begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end else begin
                n_rej = 1'b1;
            end
        end

        good         = !n_rej && !(n_mode == MODE_PREFIX && n_obd);
        result.value = good ? n_acc : '0;
        result.ok    = good;

        if (o_pop && i_q_item.last) begin
            n_pos   = '0;
            n_fz    = 1'b0;
            n_mode  = MODE_PREFIX;
            n_pv    = '0;
            n_radix = BASE_DEC;
            n_acc   = '0;
            n_obd   = 1'b0;
            n_rej   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_fz        <= 1'b0;
            r_mode      <= MODE_PREFIX;
            r_pv        <= '0;
            r_radix     <= BASE_DEC;
            r_acc       <= '0;
            r_obd       <= 1'b0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_fz    <= n_fz;
            r_mode  <= n_mode;
            r_pv    <= n_pv;
            r_radix <= n_radix;
            r_acc   <= n_acc;
            r_obd   <= n_obd;
            r_rej   <= n_rej;
            if (o_pop && i_q_item.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_item.last) begin
            r_out_data <= result;
        end
    end

    `ASSERT_IMPLIES(a_digits_radix, i_clk, i_rst_n, r_mode == MODE_DIGITS,
                    r_radix >= BASE_MIN && r_radix <= BASE_MAX)
    `ASSERT_IMPLIES(a_prefix_radix, i_clk, i_rst_n, r_mode == MODE_PREFIX,
                    r_radix == BASE_OCT || r_radix == BASE_DEC)
    `ASSERT_IMPLIES(a_out_hold, i_clk, i_rst_n, r_out_valid && i_out_stall,
                    !(o_pop && i_q_item.last))
    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, o_pop && i_q_item.last,
                 r_pos == 2'd0 && !r_rej && r_acc == '0)

endmodule
`default_nettype wire

>>> sv/radix_literal_parser.sv
// A result is registered when its token's last item is popped from the queue.
// Throughput: one item per cycle while nothing stalls; the base multiply-accumulate
// loop is combinational, and a queue between front and back absorbs output stalls.
// Reset: synchronous, active low; clears handshake, queue and parse state at once,
// no clearing pass.
`default_nettype none
module radix_literal_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rlp_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rlp_pkg::t_out_item      o_out_data
);
    import rlp_pkg::*;

    logic      f_valid;
    t_cls_item f_item;
    logic      q_full;
    logic      q_valid;
    t_cls_item q_item;
    logic      q_pop;

    rlp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_full       (q_full),
        .o_item_valid (f_valid),
        .o_item       (f_item)
    );

    rlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .i_push_item (f_item),
        .o_full      (q_full),
        .o_pop_valid (q_valid),
        .o_pop_item  (q_item),
        .i_pop       (q_pop)
    );

    rlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
